@@ hw/rtl/mvt_pkg.sv @@
// ----------------------------------------------------------------------------
// Matrix-vector transform package
// Shared field types, register map constants and pipeline control struct.
// ----------------------------------------------------------------------------
package mvt_pkg;

  // Width of every vector and result field on the channels.
  localparam int FieldBits  = 32;
  // Configuration register map.
  localparam int NumRegs    = 8;
  localparam int RegBits    = 64;
  localparam int CfgIdxBits = 3;

  typedef logic signed [FieldBits-1:0] field_t;
  typedef logic [CfgIdxBits-1:0]       cfg_idx_t;
  typedef logic [RegBits-1:0]          cfg_data_t;

  // Reset contents of the matrix registers: the identity in Q16.16.
  localparam logic [RegBits-1:0] ResetVals [NumRegs] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  // Load enables of the four pipeline stages.
  typedef struct packed {
    logic s1;  // product registers
    logic s2;  // pair sums
    logic s3;  // row totals with the half step added
    logic s4;  // saturated output words
  } stage_en_t;

endpackage

@@ hw/rtl/mvt_in_if.sv @@
// ----------------------------------------------------------------------------
// Input vector channel
// Valid/ready channel that carries one homogeneous vector per transaction.
// ----------------------------------------------------------------------------
interface mvt_in_if;
  import mvt_pkg::*;

  logic   valid;
  logic   ready;
  field_t in_x;
  field_t in_y;
  field_t in_z;
  field_t in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                  output ready);
endinterface

@@ hw/rtl/mvt_out_if.sv @@
// ----------------------------------------------------------------------------
// Output vector channel
// Valid/ready channel that carries one transformed vector per transaction.
// ----------------------------------------------------------------------------
interface mvt_out_if;
  import mvt_pkg::*;

  logic   valid;
  logic   ready;
  field_t out_x;
  field_t out_y;
  field_t out_z;
  field_t out_w;
  logic   saturated;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output out_w, output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input out_w, input saturated, output ready);
endinterface

@@ hw/rtl/mvt_lane.sv @@
// ----------------------------------------------------------------------------
// Row lane
// Multiplies one matrix row with the vector and sums the products at full
// precision, with the rounding half step already added.
// ----------------------------------------------------------------------------
module mvt_lane #(
  parameter int DIM       = 4,
  parameter int WORD_BITS = 32,
  localparam int AccBits  = 2 * WORD_BITS + 2
) (
  input  logic                        clk_i,
  input  mvt_pkg::stage_en_t          en_i,
  input  logic signed [WORD_BITS-1:0] row_i [DIM],
  input  logic signed [WORD_BITS-1:0] vec_i [DIM],
  output logic signed [AccBits-1:0]   sum_o
);
  import mvt_pkg::*;

  localparam int ProdBits = 2 * WORD_BITS;
  localparam logic signed [AccBits-1:0] Half =
    signed'(AccBits'(1) << (WORD_BITS / 2 - 1));

  logic signed [ProdBits-1:0] prod_q   [DIM];
  logic signed [ProdBits-1:0] prod_ext [4];
  logic signed [AccBits-1:0]  pair_q   [2];
  logic signed [AccBits-1:0]  sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int j = 0; j < DIM; j++) begin
        prod_q[j] <= row_i[j] * vec_i[j];
      end
    end
  end

  // Columns beyond the dimension in use contribute nothing.
  for (genvar j = 0; j < 4; j++) begin : g_pad
    if (j < DIM) begin : g_used
      assign prod_ext[j] = prod_q[j];
    end else begin : g_unused
      assign prod_ext[j] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      pair_q[0] <= AccBits'(prod_ext[0]) + AccBits'(prod_ext[1]);
      pair_q[1] <= AccBits'(prod_ext[2]) + AccBits'(prod_ext[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      sum_q <= pair_q[0] + pair_q[1] + Half;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ hw/rtl/mvt_merge.sv @@
// ----------------------------------------------------------------------------
// Result merge
// Scales the lane totals back to the word format, saturates them and
// combines the per-lane clip flags into one saturation bit.
// ----------------------------------------------------------------------------
module mvt_merge #(
  parameter int DIM       = 4,
  parameter int WORD_BITS = 32,
  localparam int AccBits  = 2 * WORD_BITS + 2
) (
  input  logic                      clk_i,
  input  mvt_pkg::stage_en_t        en_i,
  input  logic signed [AccBits-1:0] sum_i [DIM],
  output mvt_pkg::field_t           word_o [4],
  output logic                      sat_o
);
  import mvt_pkg::*;

  localparam int FracBits = WORD_BITS / 2;
  localparam longint MaxWord = (longint'(1) <<< (WORD_BITS - 1)) - 1;
  localparam longint MinWord = -MaxWord - 1;
  localparam logic signed [AccBits-1:0] MaxAcc = AccBits'(MaxWord);
  localparam logic signed [AccBits-1:0] MinAcc = AccBits'(MinWord);
  localparam logic signed [WORD_BITS-1:0] MaxW = WORD_BITS'(MaxWord);
  localparam logic signed [WORD_BITS-1:0] MinW = WORD_BITS'(MinWord);

  field_t     word_d [4];
  logic [3:0] flag_d;
  field_t     word_q [4];
  logic       sat_q;

  for (genvar r = 0; r < 4; r++) begin : g_row
    if (r < DIM) begin : g_used
      logic signed [AccBits-1:0]   shifted;
      logic                        hi;
      logic                        lo;
      logic signed [WORD_BITS-1:0] res_w;
      assign shifted   = sum_i[r] >>> FracBits;
      assign hi        = shifted > MaxAcc;
      assign lo        = shifted < MinAcc;
      assign res_w     = hi ? MaxW : (lo ? MinW : shifted[WORD_BITS-1:0]);
      assign word_d[r] = FieldBits'(res_w);
      assign flag_d[r] = hi | lo;
    end else begin : g_unused
      // Rows beyond the dimension in use read as zero.
      assign word_d[r] = '0;
      assign flag_d[r] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      word_q <= word_d;
      sat_q  <= |flag_d;
    end
  end

  assign word_o = word_q;
  assign sat_o  = sat_q;

endmodule

@@ hw/rtl/matrix_vector_transform_4x4_core.sv @@
// ----------------------------------------------------------------------------
// 4x4 homogeneous matrix-vector transform
// Multiplies each incoming vector by a configurable signed fixed-point matrix.
// ----------------------------------------------------------------------------
// The block takes one vector (x, y, z, w) per input transaction and returns
// M * v on the output channel, one result transaction per input transaction,
// in order. It sustains one transaction per clock cycle while the output
// channel accepts results. An accepted vector passes the multiplier
// registers, the adder tree of each row lane and the rounding shift with
// saturation before its result appears. The matrix lives in eight 64-bit
// registers, two entries each (lower column in the low half), written through
// the plain configuration port; after reset the matrix is the identity.
// Entries and components are signed with WORD_BITS/2 fraction bits (Q16.16 at
// the default width). Each row is summed exactly, rounded to nearest with ties
// toward plus infinity, and clipped to the word range; the saturated flag is
// set when any component was clipped. Write the matrix only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_core #(
  parameter int DIM       = 4,
  parameter int WORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  mvt_pkg::cfg_idx_t   cfg_idx_i,
  input  mvt_pkg::cfg_data_t  cfg_data_i,
  mvt_in_if.sink              in_i,
  mvt_out_if.source           out_o
);
  import mvt_pkg::*;

  localparam int AccBits  = 2 * WORD_BITS + 2;
  localparam int UsedRegs = 2 * DIM;
  localparam int HalfBits = 2 * WORD_BITS;

  // Matrix registers. Only the rows in use are stored, and only the bits
  // that hold the two entries of each register.
  logic [HalfBits-1:0] cfg_q [UsedRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < UsedRegs; i++) begin
        cfg_q[i] <= ResetVals[i][HalfBits-1:0];
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < UsedRegs; i++) begin
        if (cfg_idx_i == CfgIdxBits'(i)) begin
          cfg_q[i] <= cfg_data_i[HalfBits-1:0];
        end
      end
    end
  end

  // Unpack the matrix entries; entry (r, c) sits in register 2r + c/2.
  logic signed [WORD_BITS-1:0] mat [DIM][DIM];

  for (genvar r = 0; r < DIM; r++) begin : g_mrow
    for (genvar c = 0; c < DIM; c++) begin : g_mcol
      assign mat[r][c] = cfg_q[2 * r + c / 2][(c % 2) * WORD_BITS +: WORD_BITS];
    end
  end

  // Only the low WORD_BITS bits of each input component take part.
  field_t                      in_vec [4];
  logic signed [WORD_BITS-1:0] vec    [DIM];

  assign in_vec[0] = in_i.in_x;
  assign in_vec[1] = in_i.in_y;
  assign in_vec[2] = in_i.in_z;
  assign in_vec[3] = in_i.in_w;

  for (genvar j = 0; j < DIM; j++) begin : g_vec
    assign vec[j] = in_vec[j][WORD_BITS-1:0];
  end

  // Pipeline control. Each stage loads when it is empty or when the stage
  // after it moves on, so bubbles close up even while the output stalls.
  logic [3:0] valid_q;
  logic [3:0] valid_d;
  stage_en_t  en;

  assign en.s4 = !valid_q[3] || out_o.ready;
  assign en.s3 = !valid_q[2] || en.s4;
  assign en.s2 = !valid_q[1] || en.s3;
  assign en.s1 = !valid_q[0] || en.s2;

  always_comb begin
    valid_d    = valid_q;
    if (en.s1) valid_d[0] = in_i.valid;
    if (en.s2) valid_d[1] = valid_q[0];
    if (en.s3) valid_d[2] = valid_q[1];
    if (en.s4) valid_d[3] = valid_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_i.ready = en.s1;

  // One lane per matrix row, all working on the same vector.
  logic signed [AccBits-1:0] lane_sum [DIM];

  for (genvar r = 0; r < DIM; r++) begin : g_lane
    mvt_lane #(
      .DIM       (DIM),
      .WORD_BITS (WORD_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .row_i (mat[r]),
      .vec_i (vec),
      .sum_o (lane_sum[r])
    );
  end

  // Scale, saturate and merge the lane results into the output register.
  field_t out_word [4];
  logic   out_sat;

  mvt_merge #(
    .DIM       (DIM),
    .WORD_BITS (WORD_BITS)
  ) u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (lane_sum),
    .word_o (out_word),
    .sat_o  (out_sat)
  );

  assign out_o.valid     = valid_q[3];
  assign out_o.out_x     = out_word[0];
  assign out_o.out_y     = out_word[1];
  assign out_o.out_z     = out_word[2];
  assign out_o.out_w     = out_word[3];
  assign out_o.saturated = out_sat;

endmodule

@@ verif/mvt_transform_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix-vector transform checker
// Watches the configuration port and both vector channels, keeps its own copy
// of the matrix, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module mvt_transform_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  mvt_pkg::cfg_idx_t  cfg_idx_i,
  input  mvt_pkg::cfg_data_t cfg_data_i,
  mvt_in_if                  in_mon,
  mvt_out_if                 out_mon,
  output int                 mismatch_count_o,
  output int                 in_flight_o
);
  import mvt_pkg::*;

  typedef struct {
    field_t x;
    field_t y;
    field_t z;
    field_t w;
    logic   saturated;
  } vec_result_t;

  // The exact row sum needs 66 bits; two more keep the rounding add safe.
  typedef logic signed [67:0] wide_t;

  localparam wide_t WordMax = 68'sd2147483647;
  localparam wide_t WordMin = -68'sd2147483648;
  localparam wide_t HalfLsb = 68'sd32768;

  cfg_data_t   matrix_q [NumRegs];
  vec_result_t transformed_q [$];
  int          mismatches = 0;

  assign mismatch_count_o = mismatches;

  // Product of the shadow matrix and one vector, rounded and clipped.
  function automatic vec_result_t transform_vector(field_t x, field_t y, field_t z,
                                                   field_t w);
    vec_result_t res;
    field_t      comps [4];
    field_t      rows [4];
    field_t      ent;
    cfg_data_t   word;
    wide_t       acc;
    wide_t       e_wide;
    wide_t       v_wide;
    logic        sat;
    comps = '{x, y, z, w};
    sat   = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        word   = matrix_q[2 * r + c / 2];
        ent    = (c % 2 == 1) ? word[63:32] : word[31:0];
        e_wide = ent;
        v_wide = comps[c];
        acc    = acc + e_wide * v_wide;
      end
      // Adding half a step before the floor shift sends ties upward.
      acc = (acc + HalfLsb) >>> 16;
      if (acc > WordMax) begin
        acc = WordMax;
        sat = 1'b1;
      end else if (acc < WordMin) begin
        acc = WordMin;
        sat = 1'b1;
      end
      rows[r] = acc[31:0];
    end
    res.x         = rows[0];
    res.y         = rows[1];
    res.z         = rows[2];
    res.w         = rows[3];
    res.saturated = sat;
    return res;
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vec_result_t want;
    if (!rst_ni) begin
      foreach (matrix_q[i]) matrix_q[i] = ResetVals[i];
      transformed_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (transformed_q.size() == 0) begin
          $error("result transaction with no vector waiting for it");
          mismatches++;
        end else begin
          want = transformed_q.pop_front();
          compare_field("out_x", want.x, out_mon.out_x);
          compare_field("out_y", want.y, out_mon.out_y);
          compare_field("out_z", want.z, out_mon.out_z);
          compare_field("out_w", want.w, out_mon.out_w);
          compare_field("saturated", {31'b0, want.saturated}, {31'b0, out_mon.saturated});
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        transformed_q.push_back(transform_vector(in_mon.in_x, in_mon.in_y,
                                                 in_mon.in_z, in_mon.in_w));
      end
      if (cfg_we_i) begin
        matrix_q[cfg_idx_i] = cfg_data_i;
      end
    end
    in_flight_o <= transformed_q.size();
  end

endmodule

@@ verif/matrix_vector_transform_4x4_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix-vector transform testbench
// Drives vectors and matrix writes into the 4x4 transform core and lets the
// checker predict and compare every result under varying channel pressure.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_core_test;
  import mvt_pkg::*;

  // Matrix register indexes, in the order of the register map.
  typedef enum cfg_idx_t {
    RegRow0Cols01, RegRow0Cols23, RegRow1Cols01, RegRow1Cols23,
    RegRow2Cols01, RegRow2Cols23, RegRow3Cols01, RegRow3Cols23
  } mat_reg_e;

  // Value classes used when drawing random matrix entries and components.
  typedef enum int {
    WordFull, WordSmall, WordExtreme, WordTiny
  } word_kind_e;

  localparam mat_reg_e RowRegs [4][2] = '{
    '{RegRow0Cols01, RegRow0Cols23}, '{RegRow1Cols01, RegRow1Cols23},
    '{RegRow2Cols01, RegRow2Cols23}, '{RegRow3Cols01, RegRow3Cols23}
  };

  localparam field_t WordMax   = 32'sh7FFF_FFFF;
  localparam field_t WordMin   = 32'sh8000_0000;
  localparam field_t One       = 32'sh0001_0000;
  localparam field_t Half      = 32'sh0000_8000;
  localparam field_t MinusHalf = 32'shFFFF_8000;

  localparam int SegmentItems = 100;
  localparam int HoldCycles   = 80;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_data;

  int mismatches;
  int in_flight;

  // Idle percentages of the two sides, changed between phases.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // The stimulus asks for a long receiver hold-off by bumping hold_asked; the
  // receiver process notices the difference and counts the stretch itself.
  int hold_asked = 0;

  // Host copy of the matrix that is about to be written.
  field_t mtx [4][4];

  mvt_in_if  vec_in ();
  mvt_out_if vec_out ();

  matrix_vector_transform_4x4_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (vec_in),
    .out_o      (vec_out)
  );

  mvt_transform_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_mon           (vec_in),
    .out_mon          (vec_out),
    .mismatch_count_o (mismatches),
    .in_flight_o      (in_flight)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4_000_000;
    $display("[matrix_vector_transform_4x4_core] ERROR");
    $finish;
  end

  // Result side. Ready is redrawn every cycle from the current idle
  // percentage, except during a requested hold-off, when it stays low until
  // the stretch is over so the pipeline fills and backs up onto the input.
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left   = 0;
    vec_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        vec_out.ready <= 1'b0;
        hold_left--;
      end else if (hold_asked != hold_served) begin
        hold_served++;
        hold_left = HoldCycles - 1;
        vec_out.ready <= 1'b0;
      end else begin
        vec_out.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offers one vector, with random idle cycles in front of it, and returns at
  // the edge at which the transaction is accepted. Valid is left high so that
  // a following call can present the next vector without a gap.
  task automatic send_vector(field_t x, field_t y, field_t z, field_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      vec_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    vec_in.valid <= 1'b1;
    vec_in.in_x  <= x;
    vec_in.in_y  <= y;
    vec_in.in_z  <= z;
    vec_in.in_w  <= w;
    do @(posedge clk_i); while (!vec_in.ready);
  endtask

  // Stops offering and waits until every predicted result has come back,
  // then lets the pipeline latency pass so the block is surely idle. The
  // first edge lets the checker's count include a vector accepted just now.
  task automatic drain();
    vec_in.valid <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes the whole host matrix, two entries per register, lower column in
  // the low half. Write enable stays high across the eight writes.
  task automatic load_matrix();
    for (int r = 0; r < 4; r++) begin
      for (int p = 0; p < 2; p++) begin
        cfg_we   <= 1'b1;
        cfg_idx  <= RowRegs[r][p];
        cfg_data <= {mtx[r][2 * p + 1], mtx[r][2 * p]};
        @(posedge clk_i);
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic fill_matrix(field_t v);
    foreach (mtx[r, c]) mtx[r][c] = v;
  endtask

  function automatic field_t rand_word(word_kind_e kind);
    logic [31:0] r;
    r = $urandom;
    case (kind)
      WordFull:  return r;
      WordSmall: return {{12{r[19]}}, r[19:0]};
      WordTiny:  return {{16{r[15]}}, r[15:0]};
      default: begin
        case ($urandom_range(4))
          0:       return WordMax;
          1:       return WordMin;
          2:       return '0;
          3:       return -32'sd1;
          default: return One;
        endcase
      end
    endcase
  endfunction

  // Vector components lean toward small values so that most results stay in
  // range, with full-width and extreme values mixed in to reach saturation.
  function automatic field_t rand_component();
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) return rand_word(WordFull);
    if (pick < 7) return rand_word(WordSmall);
    if (pick < 8) return rand_word(WordExtreme);
    return rand_word(WordTiny);
  endfunction

  // Matrix styles: small entries, a per-entry mix of every class, or full
  // random words (which mostly saturate).
  task automatic random_matrix(int style);
    foreach (mtx[r, c]) begin
      case (style)
        0:       mtx[r][c] = rand_word(WordSmall);
        2:       mtx[r][c] = rand_word(WordFull);
        default: mtx[r][c] = rand_word(word_kind_e'($urandom_range(3)));
      endcase
    end
    load_matrix();
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= RegRow0Cols01;
    cfg_data     <= '0;
    vec_in.valid <= 1'b0;
    vec_in.in_x  <= '0;
    vec_in.in_y  <= '0;
    vec_in.in_z  <= '0;
    vec_in.in_w  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part. The reset matrix is the identity, so these vectors
    // should come back unchanged, extremes and alternating bit patterns too.
    send_vector('0, '0, '0, '0);
    send_vector(WordMax, WordMin, -32'sd1, 32'sd1);
    send_vector(WordMin, WordMax, 32'sd1, -32'sd1);
    send_vector(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_FFFF, 32'shFFFF_0000);
    drain();

    // Rounding ties: half-unit diagonal entries times small odd inputs
    // land exactly halfway, and must round toward plus infinity in both signs.
    // Row 0 also sums two half-products, which can cancel or add to a whole.
    fill_matrix('0);
    mtx[0][0] = Half;
    mtx[0][1] = Half;
    mtx[1][1] = Half;
    mtx[2][2] = Half;
    mtx[3][3] = MinusHalf;
    load_matrix();
    send_vector(32'sd1, -32'sd1, 32'sd3, -32'sd3);
    send_vector(-32'sd1, 32'sd1, -32'sd3, 32'sd3);
    send_vector(32'sd1, 32'sd1, 32'sd5, 32'sd7);
    drain();

    // Largest entries everywhere: saturation upward and downward, and one in-range result.
    fill_matrix(WordMax);
    load_matrix();
    send_vector(WordMax, WordMax, WordMax, WordMax);
    send_vector(WordMin, WordMin, WordMin, WordMin);
    send_vector(32'sd1, '0, '0, '0);
    drain();

    // Most negative entries: the row sum reaches 2^64 before rounding, and an
    // alternating vector cancels down to a small in-range value.
    fill_matrix(WordMin);
    load_matrix();
    send_vector(WordMin, WordMin, WordMin, WordMin);
    send_vector(WordMax, WordMax, WordMax, WordMax);
    send_vector(WordMax, WordMin, WordMax, WordMin);
    drain();

    fill_matrix('0);
    load_matrix();
    send_vector(WordMax, WordMin, 32'sh1234_5678, -32'sd1);
    drain();

    // Random part in three phases of channel pressure. Each phase runs four
    // segments, and each segment starts from a freshly written matrix.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 16;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        random_matrix(seg % 3);
        // With neither side idling, hold the receiver off for a long stretch
        // while vectors keep coming, so the core must stall its input.
        if (phase == 2 && seg == 0) hold_asked++;
        for (int n = 0; n < SegmentItems; n++) begin
          // Once per phase the sender waits for the pipeline to run empty.
          if (seg == 1 && n == SegmentItems / 2) begin
            vec_in.valid <= 1'b0;
            @(posedge clk_i);
            while (in_flight != 0) @(posedge clk_i);
          end
          send_vector(rand_component(), rand_component(), rand_component(),
                      rand_component());
        end
        drain();
      end
    end

    // Final settle: everything sent has been drained; a last wait catches
    // any stray result transaction the core might still produce.
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && in_flight == 0) begin
      $display("[matrix_vector_transform_4x4_core] OK");
    end else begin
      $display("[matrix_vector_transform_4x4_core] ERROR");
    end
    $finish;
  end

endmodule
